>>> design/swz_pkg.sv
// Shared constants, register indexes, result codes and divider request type.
package swz_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned DVS_W  = 40;
  localparam int unsigned NB_W   = 7;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [IDX_W-1:0] REG_FLOOR     = 8'd1;

  localparam logic [CFG_W-1:0] THR_RESET   = 16'd300;
  localparam logic [CFG_W-1:0] FLOOR_RESET = 16'd0;

  localparam logic [1:0] ST_WARM    = 2'd0;
  localparam logic [1:0] ST_NORMAL  = 2'd1;
  localparam logic [1:0] ST_ANOMALY = 2'd2;

  localparam logic [DVS_W-1:0] Z_SCALE   = 40'd100;
  localparam logic [DVS_W-1:0] FLOOR_DIV = 40'd1000;

  typedef struct packed {
    logic            start;
    logic [NB_W-1:0] nbits;
  } div_req_t;

endpackage

>>> design/swz_div.sv
// Restoring divider: one quotient bit per cycle, dividend left-aligned by the caller.
module swz_div #(
  parameter int unsigned DivW = 69
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  swz_pkg::div_req_t         req_i,
  input  logic [DivW-1:0]           dividend_i,
  input  logic [swz_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [DivW-1:0]           quotient_o
);
  import swz_pkg::*;

  logic              busy_q, done_q;
  logic [NB_W-1:0]   cnt_q;
  logic [DivW-1:0]   quo_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              take;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NB_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], take};
      rem_q <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> design/sliding_window_zscore_gate_core.sv
// Sliding-window z-score gate: top level with window store, sequencer and shared units.
//
// One signed sample per request; one result per request. While the window of WINDOW
// samples is filling, a request is answered in the next cycle with status warming up
// and z 0. Once full, a request takes two passes over the window memory (sum, then
// sum of squares through a registered 32x32 multiplier), three divisions by a
// constant (mean, variance, deviation floor) worked a byte digit at a time by
// reciprocal multiplication, a 32-step square root and a restoring divide at one
// quotient bit per cycle for z.
// The input is stalled while a score is worked out and while an unread result is held.
module sliding_window_zscore_gate_core #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [31:0]        sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic signed [31:0]        z_score_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [swz_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [swz_pkg::CFG_W-1:0] cfg_data_i
);
  import swz_pkg::*;

  localparam int unsigned AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned SUM_W = DATA_W + AW + 1;
  localparam int unsigned ACC_W = 2 * DATA_W + AW;
  localparam int unsigned PRD_W = DATA_W + CFG_W;

  localparam int unsigned CD_SH  = 28;
  localparam int unsigned SUM_CH = (SUM_W + 7) / 8;
  localparam int unsigned ACC_CH = (ACC_W + 7) / 8;
  localparam int unsigned PRD_CH = (PRD_W + 7) / 8;
  localparam int unsigned CD_W   = 8 * ACC_CH;
  localparam logic [9:0]  D_WIN  = 10'(WINDOW);
  localparam logic [9:0]  D_KILO = 10'(FLOOR_DIV);
  localparam logic [27:0] M_WIN  =
    28'(((64'd1 << CD_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [27:0] M_KILO =
    28'(((64'd1 << CD_SH) + 64'(FLOOR_DIV) - 64'd1) / 64'(FLOOR_DIV));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_MEAN = 4'd2;
  localparam logic [3:0] S_VAR  = 4'd3;
  localparam logic [3:0] S_VDIV = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_FDIV = 4'd6;
  localparam logic [3:0] S_ZDIV = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]              state_q, state_d;
  logic [CW-1:0]           rd_cnt_q;
  logic [2:0]              vld_q;
  logic [AW-1:0]           wr_ptr_q;
  logic                    full_q;
  logic                    out_valid_q;
  logic [CFG_W-1:0]        thr_q, floor_q;

  logic [DATA_W-1:0]       mem [WINDOW];
  logic signed [DATA_W-1:0] rdata_q, sample_q, mean_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0]        abs_sum;
  logic [ACC_W-1:0]        acc_q;
  logic [DATA_W-1:0]       ad_q, absmean_q, absdev_q;
  logic [2*DATA_W-1:0]     sq_q;
  logic [PRD_W-1:0]        prod_q;
  logic [DVS_W-1:0]        num_q, zq_q;
  logic                    devneg_q;
  logic signed [DATA_W:0]  diff_w, diff_x;
  logic [63:0]             sv_q, sr_q, sbit_q, st, sv_d, sr_d;
  logic [DATA_W-1:0]       sd_q;
  logic [DVS_W-1:0]        fv, sd_ext, sd_eff;
  logic [1:0]              status_q;
  logic signed [DATA_W-1:0] z_q, z_d;
  logic [1:0]              status_d;

  logic                    in_accept, out_free, issue, pass_done, sq_last, mem_we;
  logic [DATA_W-1:0]       mem_wdata, mq;

  div_req_t                div_req;
  logic [DVS_W-1:0]        div_quo;
  logic                    div_busy, div_done;

  logic [CD_W-1:0]         cd_dvd_q, cd_quo_q, cd_dvd;
  logic [9:0]              cd_rem_q;
  logic [17:0]             cd_x_q, cd_x, cd_sub;
  logic [7:0]              cd_qd_q;
  logic [3:0]              cd_cnt_q, cd_nch;
  logic                    cd_kilo_q, cd_ph_q, cd_busy_q, cd_done_q;
  logic                    cd_start, cd_kilo;
  logic [45:0]             cd_prod;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign issue     = (state_q == S_SUM || state_q == S_VAR) && (rd_cnt_q != CW'(WINDOW));
  assign pass_done = (rd_cnt_q == CW'(WINDOW)) && (vld_q == 3'b000);
  assign sq_last   = sbit_q[0];
  assign mem_we    = (in_accept && !full_q) || (state_q == S_OUT && out_free);
  assign mem_wdata = (state_q == S_IDLE) ? sample_i : sample_q;

  assign abs_sum = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign mq      = cd_quo_q[DATA_W-1:0];
  assign diff_w  = {rdata_q[DATA_W-1], rdata_q} - {mean_q[DATA_W-1], mean_q};
  assign diff_x  = {sample_q[DATA_W-1], sample_q} - {mean_q[DATA_W-1], mean_q};

  // square root step
  assign st   = sr_q + sbit_q;
  assign sv_d = (sv_q >= st) ? sv_q - st : sv_q;
  assign sr_d = (sv_q >= st) ? (sr_q >> 1) + sbit_q : sr_q >> 1;

  // raise the deviation to the floor, never below one
  assign fv     = (cd_quo_q[DVS_W-1:0] == '0) ? DVS_W'(1) : cd_quo_q[DVS_W-1:0];
  assign sd_ext = DVS_W'(sd_q);
  assign sd_eff = (sd_ext < fv) ? fv : sd_ext;

  // constant divide: one byte digit at a time, quotient digit by reciprocal multiply
  assign cd_x    = {cd_rem_q, cd_dvd_q[CD_W-1 -: 8]};
  assign cd_prod = 46'(cd_x) * 46'(cd_kilo_q ? M_KILO : M_WIN);
  assign cd_sub  = cd_x_q - 18'(cd_qd_q) * 18'(cd_kilo_q ? D_KILO : D_WIN);

  always_comb begin
    cd_start      = 1'b0;
    cd_kilo       = 1'b0;
    cd_nch        = '0;
    cd_dvd        = '0;
    div_req.start = 1'b0;
    div_req.nbits = NB_W'(DVS_W);
    case (state_q)
      S_SUM: begin
        cd_start = pass_done;
        cd_nch   = 4'(SUM_CH);
        cd_dvd   = CD_W'(abs_sum) << (CD_W - 8 * SUM_CH);
      end
      S_VAR: begin
        cd_start = pass_done;
        cd_nch   = 4'(ACC_CH);
        cd_dvd   = CD_W'(acc_q) << (CD_W - 8 * ACC_CH);
      end
      S_SQRT: begin
        cd_start = sq_last;
        cd_kilo  = 1'b1;
        cd_nch   = 4'(PRD_CH);
        cd_dvd   = CD_W'(prod_q) << (CD_W - 8 * PRD_CH);
      end
      S_FDIV: begin
        div_req.start = cd_done_q;
      end
      default: begin
        cd_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_busy_q <= 1'b0;
      cd_done_q <= 1'b0;
      cd_ph_q   <= 1'b0;
      cd_cnt_q  <= '0;
    end else begin
      cd_done_q <= 1'b0;
      if (cd_start && !cd_busy_q) begin
        cd_busy_q <= 1'b1;
        cd_ph_q   <= 1'b0;
        cd_cnt_q  <= cd_nch;
      end else if (cd_busy_q) begin
        cd_ph_q <= !cd_ph_q;
        if (cd_ph_q) begin
          cd_cnt_q <= cd_cnt_q - 1'b1;
          if (cd_cnt_q == 4'd1) begin
            cd_busy_q <= 1'b0;
            cd_done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cd_start && !cd_busy_q) begin
      cd_dvd_q  <= cd_dvd;
      cd_quo_q  <= '0;
      cd_rem_q  <= '0;
      cd_kilo_q <= cd_kilo;
    end else if (cd_busy_q) begin
      if (!cd_ph_q) begin
        cd_x_q  <= cd_x;
        cd_qd_q <= cd_prod[CD_SH+7:CD_SH];
      end else begin
        cd_rem_q <= cd_sub[9:0];
        cd_quo_q <= {cd_quo_q[CD_W-9:0], cd_qd_q};
        cd_dvd_q <= {cd_dvd_q[CD_W-9:0], 8'h00};
      end
    end
  end

  swz_div #(
    .DivW(DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (num_q),
    .divisor_i  (sd_eff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_accept && full_q) state_d = S_SUM;
      S_SUM:  if (pass_done) state_d = S_MEAN;
      S_MEAN: if (cd_done_q) state_d = S_VAR;
      S_VAR:  if (pass_done) state_d = S_VDIV;
      S_VDIV: if (cd_done_q) state_d = S_SQRT;
      S_SQRT: if (sq_last) state_d = S_FDIV;
      S_FDIV: if (cd_done_q) state_d = S_ZDIV;
      S_ZDIV: if (div_done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // saturate the z score and grade it
  always_comb begin
    if (devneg_q) begin
      z_d = (zq_q > DVS_W'(40'h0080000000)) ? 32'sh80000000 : -$signed(zq_q[DATA_W-1:0]);
    end else begin
      z_d = (zq_q > DVS_W'(40'h007FFFFFFF)) ? 32'sh7FFFFFFF : $signed(zq_q[DATA_W-1:0]);
    end
    status_d = (zq_q >= DVS_W'(thr_q)) ? ST_ANOMALY : ST_NORMAL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      vld_q       <= '0;
      wr_ptr_q    <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= THR_RESET;
      floor_q     <= FLOOR_RESET;
    end else begin
      state_q <= state_d;
      vld_q   <= {vld_q[1:0], issue};
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end else if (state_q == S_IDLE || state_q == S_MEAN) begin
        rd_cnt_q <= '0;
      end
      if (mem_we) begin
        if (wr_ptr_q == AW'(WINDOW - 1)) begin
          wr_ptr_q <= '0;
          full_q   <= 1'b1;
        end else begin
          wr_ptr_q <= wr_ptr_q + 1'b1;
        end
      end
      if ((in_accept && !full_q) || (state_q == S_OUT && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_THRESHOLD: thr_q   <= cfg_data_i;
          REG_FLOOR:     floor_q <= cfg_data_i;
          default:       thr_q   <= thr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_ptr_q] <= mem_wdata;
    end
    if (issue) begin
      rdata_q <= mem[rd_cnt_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q     <= diff_w[DATA_W] ? DATA_W'(-diff_w) : diff_w[DATA_W-1:0];
    sq_q     <= ad_q * ad_q;
    absdev_q <= diff_x[DATA_W] ? DATA_W'(-diff_x) : diff_x[DATA_W-1:0];
    devneg_q <= diff_x[DATA_W];
    num_q    <= DVS_W'(absdev_q) * Z_SCALE;
    prod_q   <= absmean_q * floor_q;

    if (in_accept) begin
      sample_q <= sample_i;
      sum_q    <= '0;
    end else if (state_q == S_SUM && vld_q[0]) begin
      sum_q <= sum_q + {{(SUM_W - DATA_W){rdata_q[DATA_W-1]}}, rdata_q};
    end

    if (state_q == S_MEAN) begin
      acc_q <= '0;
      if (cd_done_q) begin
        mean_q    <= sum_q[SUM_W-1] ? -$signed(mq) : $signed(mq);
        absmean_q <= mq;
      end
    end else if (state_q == S_VAR && vld_q[2]) begin
      acc_q <= acc_q + ACC_W'(sq_q);
    end

    if (state_q == S_VDIV && cd_done_q) begin
      sv_q   <= cd_quo_q[63:0];
      sr_q   <= '0;
      sbit_q <= 64'h4000000000000000;
    end else if (state_q == S_SQRT) begin
      sv_q   <= sv_d;
      sr_q   <= sr_d;
      sbit_q <= sbit_q >> 2;
      sd_q   <= sr_d[DATA_W-1:0];
    end

    if (state_q == S_ZDIV && div_done) begin
      zq_q <= div_quo;
    end

    if (in_accept && !full_q) begin
      status_q <= ST_WARM;
      z_q      <= '0;
    end else if (state_q == S_OUT && out_free) begin
      status_q <= status_d;
      z_q      <= z_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign z_score_o   = z_q;

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> state_q == S_IDLE)
    else $error("request taken while busy");

  a_warm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_WARM) |-> z_score_o == '0)
    else $error("warming-up result with nonzero z");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_score_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> full_q)
    else $error("score produced before window filled");

endmodule

>>> tb/sliding_window_zscore_gate_checker.sv
// Channel monitor, score predictor and result comparison for the z-score gate.
module sliding_window_zscore_gate_checker #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [31:0]        sample_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [1:0]                status_i,
  input  logic signed [31:0]        z_score_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [swz_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [swz_pkg::CFG_W-1:0] cfg_data_i,
  output int                        errors_o,
  output int                        pending_o
);
  import swz_pkg::*;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] z;
  } score_t;

  score_t             score_q[$];
  logic signed [31:0] hist_q[WINDOW];
  int unsigned        wr_ptr;
  int unsigned        filled;
  logic [CFG_W-1:0]   thr_q;
  logic [CFG_W-1:0]   floor_q;

  assign pending_o = score_q.size();

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Score one sample against the held window, then store it.
  function automatic score_t score_sample(logic signed [31:0] x);
    score_t       res;
    longint       total;
    longint       mean;
    longint       d;
    longint       flr;
    longint       z;
    logic [127:0] sq_acc;
    logic [63:0]  ad;
    logic [63:0]  sd;
    res.status = ST_WARM;
    res.z = '0;
    if (filled >= WINDOW) begin
      total = 0;
      for (int i = 0; i < WINDOW; i++) total += longint'(hist_q[i]);
      mean = total / longint'(WINDOW);
      sq_acc = '0;
      for (int i = 0; i < WINDOW; i++) begin
        d = longint'(hist_q[i]) - mean;
        ad = (d < 0) ? 64'(-d) : 64'(d);
        sq_acc += 128'(ad) * 128'(ad);
      end
      sd = isqrt64(64'(sq_acc / 128'(WINDOW)));
      flr = ((mean < 0) ? -mean : mean) * longint'(floor_q) / 1000;
      if (flr < 1) flr = 1;
      if (longint'(sd) < flr) sd = 64'(flr);
      z = (longint'(x) - mean) * 100 / longint'(sd);
      if (z > 64'sd2147483647) z = 64'sd2147483647;
      else if (z < -64'sd2147483648) z = -64'sd2147483648;
      res.z = 32'(z);
      res.status = (((z < 0) ? -z : z) >= longint'(thr_q)) ? ST_ANOMALY : ST_NORMAL;
    end
    hist_q[wr_ptr] = x;
    wr_ptr = (wr_ptr + 1) % WINDOW;
    if (filled < WINDOW) filled++;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    score_t want;
    if (!rst_ni) begin
      score_q.delete();
      wr_ptr = 0;
      filled = 0;
      thr_q = THR_RESET;
      floor_q = FLOOR_RESET;
      errors_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result status %0d z %0d", $time, status_i, z_score_i);
          errors_o++;
        end else begin
          want = score_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            errors_o++;
          end
          if (z_score_i !== want.z) begin
            $display("%0t: z_score expected %0d actual %0d", $time, want.z, z_score_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) score_q.push_back(score_sample(sample_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_THRESHOLD) thr_q = cfg_data_i;
        else if (cfg_index_i == REG_FLOOR) floor_q = cfg_data_i;
      end
    end
  end

endmodule

>>> tb/testbench.sv
// Stimulus, handshake pacing and verdict for the z-score gate.
module testbench;
  import swz_pkg::*;

  localparam int unsigned WIN = 32;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 8'd2;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [31:0]   sample_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           status_o;
  logic signed [31:0]   z_score_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [IDX_W-1:0]     cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   errors;
  int                   pending;
  int unsigned          cycles;
  int                   burst_left;

  sliding_window_zscore_gate_core #(.WINDOW(WIN)) dut (.*);

  sliding_window_zscore_gate_checker #(.WINDOW(WIN)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .sample_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o), .z_score_i(z_score_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random stall runs, clear runs, and now and then a long hold-off.
  initial begin
    int run;
    int mode;
    out_stall_i <= 1'b1;
    @(posedge rst_ni);
    // hold off from the start so that the first result is held and the block stalls its input
    repeat (1500) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 39);
      if (mode == 0) begin
        out_stall_i <= 1'b1;
        repeat (1500) @(posedge clk_i);
      end else begin
        run = $urandom_range(1, 400);
        repeat (run) begin
          @(posedge clk_i);
          if (mode < 14) out_stall_i <= 1'b0;
          else out_stall_i <= ($urandom_range(0, 2) == 0);
        end
      end
    end
  end

  task automatic send_sample(logic signed [31:0] x);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    sample_i <= x;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the sender until every result is back, then reprogram.
  task automatic set_gate(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] flr);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_FLOOR, flr);
  endtask

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  initial begin
    longint base;
    longint spread;
    int     len;
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] flr;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    sample_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    burst_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Warm-up on a zero window, then extremes: zero spread and saturation.
    repeat (WIN) send_sample(32'sd0);
    send_sample(32'sh7fffffff);
    send_sample(32'sh80000000);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    send_sample(32'sd299);
    // Out-of-range index must be ignored; then extreme register values.
    set_gate(16'd0, 16'd0);
    write_reg(REG_UNUSED, 16'hffff);
    send_sample(32'sd0);
    set_gate(16'hffff, 16'hffff);
    send_sample(32'sh7fffffff);
    send_sample(32'sh80000000);
    send_sample(32'sh55555555);
    send_sample(32'shaaaaaaaa);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin thr = 16'd300; flr = 16'd0; end
        1: begin thr = 16'd0; flr = 16'd65535; end
        2: begin thr = 16'd65535; flr = 16'd0; end
        default: begin
          thr = 16'($urandom_range(50, 1000));
          flr = 16'($urandom_range(0, 3000));
        end
      endcase
      set_gate(thr, flr);
      for (int n = 0; n < 150; n += len) begin
        len = $urandom_range(10, 60);
        case ($urandom_range(0, 9))
          0: base = longint'($signed($urandom()));
          1, 2: base = longint'($urandom_range(0, 2000)) - 1000;
          default: base = longint'($signed($urandom())) >>> $urandom_range(0, 28);
        endcase
        spread = longint'(1) << $urandom_range(0, 20);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) send_sample($urandom());
          else if ($urandom_range(0, 14) == 0)
            send_sample(clamp32(base + spread * (longint'($urandom_range(0, 20)) - 10)));
          else
            send_sample(clamp32(base + longint'($urandom_range(0, 32'(spread * 2))) - spread));
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sliding_window_zscore_gate_core.f
design/swz_pkg.sv
design/swz_div.sv
design/sliding_window_zscore_gate_core.sv
tb/sliding_window_zscore_gate_checker.sv
tb/testbench.sv
